### hdl/ccpc_pkg.sv
// Shared types, widths and register codes of the colour cylinder pixel classifier.
// No dependencies; every other file of the block imports this package.
package ccpc_pkg;

	// fixed-point formats
	localparam int DIST_FRAC_BITS = 6;
	localparam int AXIS_FRAC_BITS = 14;

	// register port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTRE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd4;

	localparam int PIX_W = 8;
	localparam int CMP_W = 16;   // one packed origin or axis component
	localparam int CEN_W = 17;
	localparam int LEN_W = 16;

	// datapath widths
	localparam int DIFF_W  = 18;
	localparam int AX_W    = CMP_W;
	localparam int P1_W    = DIFF_W + AX_W;
	localparam int TFULL_W = P1_W + 2;
	localparam int T_SH    = 8 + AXIS_FRAC_BITS - DIST_FRAC_BITS;
	localparam int TQ_W    = TFULL_W + 1 - T_SH;
	localparam int SC_SH   = DIST_FRAC_BITS + AXIS_FRAC_BITS - 8;
	localparam int SC_W    = DIFF_W + SC_SH;
	localparam int P2_W    = TQ_W + AX_W;
	localparam int TERM_W  = ((P2_W > SC_W) ? P2_W : SC_W) + 2;
	localparam int A_W     = TERM_W - AXIS_FRAC_BITS;
	localparam int SQ1_W   = 2 * A_W;
	localparam int SS_W    = SQ1_W + 2;
	localparam int SQ_W    = (SS_W + 1) / 2;
	localparam int SSP_W   = 2 * SQ_W;
	localparam int DTR_W   = ((TQ_W > CEN_W) ? TQ_W : CEN_W) + 1;
	localparam int DT_W    = DTR_W;
	localparam int DIST_W  = SQ_W + 1;
	localparam int D_W     = ((DT_W > DIST_W) ? DT_W : DIST_W) + 1;
	localparam int QR_W    = D_W - DIST_FRAC_BITS + 1;

	localparam logic [PIX_W-1:0] SAT_MAX  = 8'd255;
	localparam logic [PIX_W-1:0] MASK_IN  = 8'd255;
	localparam logic [PIX_W-1:0] MASK_OUT = 8'd0;

	typedef struct packed {
		logic [PIX_W-1:0] chan2;
		logic [PIX_W-1:0] chan1;
		logic [PIX_W-1:0] chan0;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] mask;
		logic [PIX_W-1:0] distance;
	} result_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] origin;
		logic [CFG_DATA_W-1:0] axis;
		logic signed [CEN_W-1:0] centre;
		logic [LEN_W-1:0] half;
		logic [LEN_W-1:0] radius;
	} cfg_t;

	// projection stage to square root pipeline
	typedef struct packed {
		logic vld;
		logic [SS_W-1:0] ss;
		logic [DT_W-1:0] dt;
	} sq_in_t;

	// square root pipeline to finishing stages
	typedef struct packed {
		logic vld;
		logic [SQ_W-1:0] root;
		logic [SQ_W+1:0] rem;
		logic [DT_W-1:0] dt;
	} sq_out_t;

endpackage

### hdl/color_cylinder_pixel_classifier_top.sv
// Colour cylinder pixel classifier, top level.
// Pipeline: done rises together with the result word;
// 7 projection, SQ_W root and 3 finishing stages.
// Throughput: one pixel per clock; busy is never raised and results cannot be held off.
// Reset: arst_n clears the config registers and pipeline valid bits at once; datapath registers are not reset.
// Depends on ccpc_pkg, ccpc_cfg_regs, ccpc_proj, ccpc_sqrt and ccpc_finish.
module color_cylinder_pixel_classifier_top import ccpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  pixel_t                pixel,
	output logic                  done,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	sq_in_t  sq_in;
	sq_out_t sq_out;
	logic    accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	ccpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ccpc_proj u_proj (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (accept),
		.pix    (pixel),
		.cfg    (cfg),
		.sq_in  (sq_in)
	);

	ccpc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.sq_in  (sq_in),
		.sq_out (sq_out)
	);

	ccpc_finish u_finish (
		.clk    (clk),
		.arst_n (arst_n),
		.sq_out (sq_out),
		.cfg    (cfg),
		.done   (done),
		.result (result)
	);

endmodule

### hdl/ccpc_cfg_regs.sv
// Configuration register file of the colour cylinder classifier.
// Depends on ccpc_pkg for register codes and the cfg_t bundle.
module ccpc_cfg_regs import ccpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ORIGIN: cfg_q.origin <= cfg_data;
				CFG_AXIS:   cfg_q.axis   <= cfg_data;
				CFG_CENTRE: cfg_q.centre <= signed'(cfg_data[CEN_W-1:0]);
				CFG_HALF:   cfg_q.half   <= cfg_data[LEN_W-1:0];
				CFG_RADIUS: cfg_q.radius <= cfg_data[LEN_W-1:0];
				default: ; // unmapped index, word dropped
			endcase
		end
	end

endmodule

### hdl/ccpc_proj.sv
// Projection front end: pixel offset, axial coordinate and excess, residual vector, sum of squares.
// Seven register stages; depends on ccpc_pkg.
module ccpc_proj import ccpc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_vld,
	input  pixel_t pix,
	input  cfg_t   cfg,
	output sq_in_t sq_in
);

	localparam logic signed [TFULL_W-1:0] T_RND = TFULL_W'(1) <<< (T_SH - 1);
	localparam logic signed [TERM_W-1:0]  A_RND = TERM_W'(1) <<< (AXIS_FRAC_BITS - 1);

	logic [PIX_W-1:0]       pix_ch [3];
	logic [CMP_W-1:0]       org    [3];
	logic signed [AX_W-1:0] ax     [3];

	logic [6:0] vld_q;

	logic signed [DIFF_W-1:0] diff_s1 [3];
	logic signed [DIFF_W-1:0] diff_s2 [3];
	logic signed [DIFF_W-1:0] diff_s3 [3];
	logic signed [DIFF_W-1:0] diff_s4 [3];
	logic signed [P1_W-1:0]   prod1_s2 [3];
	logic signed [TQ_W-1:0]   tq_s3;
	logic signed [P2_W-1:0]   prod2_s4 [3];
	logic signed [DTR_W-1:0]  dtr_s4;
	logic signed [A_W-1:0]    a_s5 [3];
	logic [DT_W-1:0]          dt_s5, dt_s6, dt_s7;
	logic [SQ1_W-1:0]         sq_s6 [3];
	logic [SS_W-1:0]          ss_s7;

	logic signed [TFULL_W-1:0] tsum;
	logic signed [TERM_W-1:0]  term [3];
	logic [DTR_W-1:0]          dt_abs;
	logic signed [DTR_W:0]     dt_ex;
	logic [A_W-1:0]            mag  [3];

	always_comb begin
		pix_ch[0] = pix.chan0;
		pix_ch[1] = pix.chan1;
		pix_ch[2] = pix.chan2;
		for (int i = 0; i < 3; i++) begin
			org[i] = cfg.origin[CMP_W*i +: CMP_W];
			ax[i]  = signed'(cfg.axis[CMP_W*i +: CMP_W]);
		end
	end

	// axial coordinate, rounded half up at T_SH
	assign tsum = TFULL_W'(prod1_s2[0]) + TFULL_W'(prod1_s2[1]) + TFULL_W'(prod1_s2[2]) + T_RND;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			term[i] = TERM_W'(prod2_s4[i]) - (TERM_W'(diff_s4[i]) <<< SC_SH) + A_RND;
			mag[i]  = a_s5[i][A_W-1] ? A_W'(-a_s5[i]) : a_s5[i];
		end
		dt_abs = dtr_s4[DTR_W-1] ? DTR_W'(-dtr_s4) : dtr_s4;
		dt_ex  = signed'({1'b0, dt_abs}) - signed'({{(DTR_W+1-LEN_W){1'b0}}, cfg.half});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[5:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			diff_s1[i]  <= signed'({{(DIFF_W-16){1'b0}}, pix_ch[i], 8'h00})
				- signed'({{(DIFF_W-CMP_W){1'b0}}, org[i]});
			prod1_s2[i] <= P1_W'(diff_s1[i]) * P1_W'(ax[i]);
			diff_s2[i]  <= diff_s1[i];
			diff_s3[i]  <= diff_s2[i];
			prod2_s4[i] <= P2_W'(tq_s3) * P2_W'(ax[i]);
			diff_s4[i]  <= diff_s3[i];
			a_s5[i]     <= A_W'(term[i] >>> AXIS_FRAC_BITS);
			sq_s6[i]    <= SQ1_W'(mag[i]) * SQ1_W'(mag[i]);
		end
		tq_s3  <= TQ_W'(tsum >>> T_SH);
		dtr_s4 <= DTR_W'(tq_s3) - DTR_W'(signed'(cfg.centre));
		dt_s5  <= dt_ex[DTR_W] ? '0 : dt_ex[DTR_W-1:0];
		dt_s6  <= dt_s5;
		dt_s7  <= dt_s6;
		ss_s7  <= SS_W'(sq_s6[0]) + SS_W'(sq_s6[1]) + SS_W'(sq_s6[2]);
	end

	assign sq_in.vld = vld_q[6];
	assign sq_in.ss  = ss_s7;
	assign sq_in.dt  = dt_s7;

endmodule

### hdl/ccpc_sqrt.sv
// Pipelined integer square root, one root bit per register stage (SQ_W stages).
// Carries the axial excess alongside; depends on ccpc_pkg.
module ccpc_sqrt import ccpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  sq_in_t  sq_in,
	output sq_out_t sq_out
);

	logic [SQ_W-1:0]  vld_s;
	logic [SQ_W-1:0]  rt_s  [SQ_W];
	logic [SQ_W+1:0]  rm_s  [SQ_W];
	logic [SSP_W-1:0] rad_s [SQ_W];
	logic [DT_W-1:0]  dt_s  [SQ_W];

	logic [SQ_W-1:0]  cur_rt  [SQ_W];
	logic [SQ_W+1:0]  cur_rm  [SQ_W];
	logic [SSP_W-1:0] cur_rad [SQ_W];
	logic [SQ_W+1:0]  rem_x   [SQ_W];
	logic [SQ_W+1:0]  trial   [SQ_W];
	logic [SQ_W-1:0]  nxt_rt  [SQ_W];
	logic [SQ_W+1:0]  nxt_rm  [SQ_W];

	// restoring digit recurrence: bring down two radicand bits, try (root<<2)|1
	always_comb begin
		for (int k = 0; k < SQ_W; k++) begin
			if (k == 0) begin
				cur_rt[k]  = '0;
				cur_rm[k]  = '0;
				cur_rad[k] = SSP_W'(sq_in.ss);
			end else begin
				cur_rt[k]  = rt_s[k-1];
				cur_rm[k]  = rm_s[k-1];
				cur_rad[k] = rad_s[k-1];
			end
			rem_x[k] = {cur_rm[k][SQ_W-1:0], cur_rad[k][SSP_W-1 -: 2]};
			trial[k] = {cur_rt[k], 2'b01};
			if (rem_x[k] >= trial[k]) begin
				nxt_rm[k] = rem_x[k] - trial[k];
				nxt_rt[k] = {cur_rt[k][SQ_W-2:0], 1'b1};
			end else begin
				nxt_rm[k] = rem_x[k];
				nxt_rt[k] = {cur_rt[k][SQ_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[SQ_W-2:0], sq_in.vld};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < SQ_W; k++) begin
			rt_s[k]  <= nxt_rt[k];
			rm_s[k]  <= nxt_rm[k];
			rad_s[k] <= cur_rad[k] << 2;
			if (k == 0) begin
				dt_s[k] <= sq_in.dt;
			end else begin
				dt_s[k] <= dt_s[k-1];
			end
		end
	end

	assign sq_out.vld  = vld_s[SQ_W-1];
	assign sq_out.root = rt_s[SQ_W-1];
	assign sq_out.rem  = rm_s[SQ_W-1];
	assign sq_out.dt   = dt_s[SQ_W-1];

endmodule

### hdl/ccpc_finish.sv
// Finishing stages: round the root, radial excess, sum, half-even rounding, saturation, mask.
// Three register stages; depends on ccpc_pkg.
module ccpc_finish import ccpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  sq_out_t sq_out,
	input  cfg_t    cfg,
	output logic    done,
	output result_t result
);

	localparam logic [DIST_FRAC_BITS-1:0] RND_HALF =
		DIST_FRAC_BITS'(1) << (DIST_FRAC_BITS - 1);

	logic [2:0] vld_q;

	logic [DIST_W-1:0] dist_s1;
	logic [DT_W-1:0]   dt_s1;
	logic [D_W-1:0]    d_s2;
	result_t           res_s3;

	logic signed [DIST_W:0]    dp_ex;
	logic [DIST_W-1:0]         dp;
	logic [D_W-DIST_FRAC_BITS-1:0] q_int;
	logic [DIST_FRAC_BITS-1:0] q_frac;
	logic                      q_inc;
	logic [QR_W-1:0]           q_rnd;
	logic [PIX_W-1:0]          q_sat;

	always_comb begin
		dp_ex = signed'({1'b0, dist_s1}) - signed'({{(DIST_W+1-LEN_W){1'b0}}, cfg.radius});
		dp    = dp_ex[DIST_W] ? '0 : dp_ex[DIST_W-1:0];

		q_int  = d_s2[D_W-1:DIST_FRAC_BITS];
		q_frac = d_s2[DIST_FRAC_BITS-1:0];
		q_inc  = (q_frac > RND_HALF) || ((q_frac == RND_HALF) && q_int[0]);
		q_rnd  = QR_W'(q_int) + QR_W'(q_inc);
		q_sat  = (q_rnd > QR_W'(SAT_MAX)) ? SAT_MAX : q_rnd[PIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[1:0], sq_out.vld};
		end
	end

	always_ff @(posedge clk) begin
		// nearest root: bump when remainder exceeds root
		dist_s1         <= DIST_W'(sq_out.root) + DIST_W'(sq_out.rem > (SQ_W+2)'(sq_out.root));
		dt_s1           <= sq_out.dt;
		d_s2            <= D_W'(dp) + D_W'(dt_s1);
		res_s3.distance <= q_sat;
		res_s3.mask     <= (q_sat == '0) ? MASK_IN : MASK_OUT;
	end

	assign done   = vld_q[2];
	assign result = res_s3;

endmodule
